// ===== hw/rtl/itoa_pkg.sv =====
// ----------------------------------------------------------------------------
// itoa_pkg
// shared constants, types and the digit-to-character mapping for the
// binary to ascii radix converter
// ----------------------------------------------------------------------------
package itoa_pkg;

   // default sizes
   localparam int VALUE_WIDTH_DEF = 64;
   localparam int MAX_DIGITS_DEF  = 64;

   // stream payload widths
   localparam int VALUE_BITS   = 64;
   localparam int RADIX_BITS   = 5;
   localparam int REQ_TDATA_W  = 72;
   localparam int RSP_TDATA_W  = 8;
   localparam int DIGIT_BITS   = 4;
   localparam int CHAR_BITS    = 7;

   // character and radix constants
   localparam logic [CHAR_BITS-1:0]  CHAR_ZERO    = 7'd48;
   localparam logic [CHAR_BITS-1:0]  CHAR_LOWER_A = 7'd97;
   localparam logic [DIGIT_BITS-1:0] DECIMAL_TEN  = 4'd10;
   localparam logic [RADIX_BITS-1:0] RADIX_MIN    = 5'd2;
   localparam logic [RADIX_BITS-1:0] RADIX_MAX    = 5'd16;

   // commands to the serial divider
   typedef struct packed {
      logic load;    // take a fresh dividend
      logic start;   // begin one division pass
   } div_ctrl_type;

   // status from the serial divider
   typedef struct packed {
      logic                  done;     // pass finished this cycle
      logic [DIGIT_BITS-1:0] digit;    // remainder of the pass
      logic                  nonzero;  // quotient of the pass is not zero
   } div_stat_type;

   function automatic logic [CHAR_BITS-1:0] digit_to_ascii(input logic [DIGIT_BITS-1:0] d);
      logic [DIGIT_BITS-1:0] above_ten;
      above_ten = d - DECIMAL_TEN;
      if (d < DECIMAL_TEN) begin
         return CHAR_ZERO + CHAR_BITS'(d);
      end else begin
         return CHAR_LOWER_A + CHAR_BITS'(above_ten);
      end
   endfunction

endpackage

// ===== hw/rtl/itoa_div.sv =====
// ----------------------------------------------------------------------------
// itoa_div
// bit-serial restoring divider by a small radix, one dividend bit per cycle
// ----------------------------------------------------------------------------
module itoa_div #(
   parameter int VALUE_WIDTH = itoa_pkg::VALUE_WIDTH_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   input  itoa_pkg::div_ctrl_type           ctrl,
   input  logic [VALUE_WIDTH-1:0]           load_value,
   input  logic [itoa_pkg::RADIX_BITS-1:0]  radix,
   output itoa_pkg::div_stat_type           stat
);

   localparam int CW = (VALUE_WIDTH > 1) ? $clog2(VALUE_WIDTH) : 1;

   logic [VALUE_WIDTH-1:0]            quo_ff, quo_in;
   logic [itoa_pkg::DIGIT_BITS-1:0]   rem_ff, rem_in;
   logic [CW-1:0]                     cnt_ff, cnt_in;
   logic                              run_ff, run_in;
   logic                              nz_ff, nz_in;
   logic                              done_ff, done_in;

   logic [itoa_pkg::RADIX_BITS-1:0]   partial;
   logic [itoa_pkg::RADIX_BITS-1:0]   diff;
   logic                              fits;
   logic                              last_bit;

   // remainder shifted left with the next dividend bit
   assign partial  = {rem_ff, quo_ff[VALUE_WIDTH-1]};
   assign diff     = partial - radix;
   assign fits     = (partial >= radix);
   assign last_bit = (cnt_ff == CW'(VALUE_WIDTH - 1));

   always_comb begin
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      cnt_in  = cnt_ff;
      run_in  = run_ff;
      nz_in   = nz_ff;
      done_in = 1'b0;
      if (run_ff) begin
         quo_in = {quo_ff[VALUE_WIDTH-2:0], fits};
         rem_in = fits ? diff[itoa_pkg::DIGIT_BITS-1:0] : partial[itoa_pkg::DIGIT_BITS-1:0];
         nz_in  = nz_ff | fits;
         cnt_in = cnt_ff + 1'b1;
         if (last_bit) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
      if (ctrl.load) begin
         quo_in = load_value;
      end
      if (ctrl.start) begin
         rem_in = '0;
         cnt_in = '0;
         nz_in  = 1'b0;
         run_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      cnt_ff <= cnt_in;
      nz_ff  <= nz_in;
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
      end
   end

   assign stat.done    = done_ff;
   assign stat.digit   = rem_ff;
   assign stat.nonzero = nz_ff;

   a_rem_below_radix : assert property (@(posedge clock) disable iff (reset)
      run_ff |-> (itoa_pkg::RADIX_BITS'(rem_ff) < radix))
      else $error("remainder not below radix");

   a_done_single : assert property (@(posedge clock) disable iff (reset)
      done_ff |=> !done_ff)
      else $error("done held longer than one cycle");

   a_start_runs : assert property (@(posedge clock) disable iff (reset)
      ctrl.start |=> (run_ff && !done_ff))
      else $error("start did not begin a pass");

endmodule

// ===== hw/rtl/integer_to_ascii_digits.sv =====
// ----------------------------------------------------------------------------
// integer_to_ascii_digits
// converts an unsigned value to ascii digits in radix 2..16, most
// significant digit first, no leading zeros, last flag on the final digit
// ----------------------------------------------------------------------------
// sequence: D digits take D serial division passes, one dividend bit per cycle,
//   then a store read state before the first character is shown
// handshake: a new request is accepted only in idle, after the final character
//   of the previous number has been taken; each character passes S_RD then S_OUT
// reset: synchronous, active high; clears the control state, digit store
//   contents stay undefined until written
module integer_to_ascii_digits #(
   parameter int VALUE_WIDTH = itoa_pkg::VALUE_WIDTH_DEF,
   parameter int MAX_DIGITS  = itoa_pkg::MAX_DIGITS_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   // request stream
   input  logic                               req_tvalid,
   output logic                               req_tready,
   input  logic [itoa_pkg::REQ_TDATA_W-1:0]   req_tdata,  // value[63:0], radix[68:64], zero pad
   // response stream
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   output logic [itoa_pkg::RSP_TDATA_W-1:0]   rsp_tdata,  // digit_char[6:0], zero pad [7]
   output logic                               rsp_tlast   // final digit of the number
);

   localparam int IW   = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;
   localparam int CNTW = $clog2(MAX_DIGITS + 1);

   // sequencer states
   localparam logic [1:0] S_IDLE = 2'd0;  // waiting for a request transfer
   localparam logic [1:0] S_DIV  = 2'd1;  // serial division, one digit per pass
   localparam logic [1:0] S_RD   = 2'd2;  // read the next digit from the store
   localparam logic [1:0] S_OUT  = 2'd3;  // character offered on the response side

   logic [1:0]                           state_ff, state_in;
   logic [CNTW-1:0]                      count_ff, count_in;
   logic [itoa_pkg::RADIX_BITS-1:0]      radix_ff, radix_in;
   logic [itoa_pkg::DIGIT_BITS-1:0]      rd_digit_ff;

   // digit store, least significant digit at entry zero
   logic [itoa_pkg::DIGIT_BITS-1:0]      digit_store [MAX_DIGITS];

   logic                                 req_xfer;
   logic                                 rsp_xfer;
   logic [itoa_pkg::RADIX_BITS-1:0]      radix_raw;
   logic [itoa_pkg::RADIX_BITS-1:0]      radix_clamped;
   logic [VALUE_WIDTH-1:0]               value_in;
   logic [CNTW-1:0]                      count_dec;
   logic [IW-1:0]                        wr_idx;
   logic [IW-1:0]                        rd_idx;
   logic                                 more_digits;
   logic                                 store_we;
   logic                                 store_re;

   itoa_pkg::div_ctrl_type               div_ctrl;
   itoa_pkg::div_stat_type               div_stat;

   // unpack the request, only the low VALUE_WIDTH bits of value count
   assign value_in  = req_tdata[VALUE_WIDTH-1:0];
   assign radix_raw = req_tdata[itoa_pkg::VALUE_BITS +: itoa_pkg::RADIX_BITS];

   always_comb begin
      if (radix_raw < itoa_pkg::RADIX_MIN) begin
         radix_clamped = itoa_pkg::RADIX_MIN;
      end else if (radix_raw > itoa_pkg::RADIX_MAX) begin
         radix_clamped = itoa_pkg::RADIX_MAX;
      end else begin
         radix_clamped = radix_raw;
      end
   end

   assign req_tready = (state_ff == S_IDLE);
   assign req_xfer   = req_tvalid && req_tready;
   assign rsp_tvalid = (state_ff == S_OUT);
   assign rsp_xfer   = rsp_tvalid && rsp_tready;

   // store addressing: write at the digit count, read one below it
   assign count_dec = count_ff - 1'b1;
   assign wr_idx    = count_ff[IW-1:0];
   assign rd_idx    = count_dec[IW-1:0];

   // keep dividing while the quotient is nonzero and the store has room
   assign more_digits = div_stat.nonzero && (count_ff != CNTW'(MAX_DIGITS - 1));
   assign store_we    = (state_ff == S_DIV) && div_stat.done;
   assign store_re    = (state_ff == S_RD);

   always_comb begin
      state_in       = state_ff;
      count_in       = count_ff;
      radix_in       = radix_ff;
      div_ctrl.load  = 1'b0;
      div_ctrl.start = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_xfer) begin
               radix_in       = radix_clamped;
               count_in       = '0;
               div_ctrl.load  = 1'b1;
               div_ctrl.start = 1'b1;
               state_in       = S_DIV;
            end
         end
         S_DIV: begin
            if (div_stat.done) begin
               count_in = count_ff + 1'b1;
               if (more_digits) begin
                  div_ctrl.start = 1'b1;
               end else begin
                  state_in = S_RD;
               end
            end
         end
         S_RD: begin
            state_in = S_OUT;
         end
         S_OUT: begin
            if (rsp_xfer) begin
               if (count_ff == CNTW'(1)) begin
                  state_in = S_IDLE;
               end else begin
                  count_in = count_dec;
                  state_in = S_RD;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      radix_ff <= radix_in;
      if (reset) begin
         state_ff <= S_IDLE;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
      end
   end

   // digit store: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (store_we) begin
         digit_store[wr_idx] <= div_stat.digit;
      end
      if (store_re) begin
         rd_digit_ff <= digit_store[rd_idx];
      end
   end

   itoa_div #(
      .VALUE_WIDTH (VALUE_WIDTH)
   ) u_div (
      .clock      (clock),
      .reset      (reset),
      .ctrl       (div_ctrl),
      .load_value (value_in),
      .radix      (radix_ff),
      .stat       (div_stat)
   );

   // response payload
   assign rsp_tdata = {1'b0, itoa_pkg::digit_to_ascii(rd_digit_ff)};
   assign rsp_tlast = (count_ff == CNTW'(1));

   a_out_has_digit : assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (count_ff != '0))
      else $error("character offered with an empty digit count");

   a_req_starts_div : assert property (@(posedge clock) disable iff (reset)
      req_xfer |=> (state_ff == S_DIV && count_ff == '0))
      else $error("request transfer did not start division");

   a_last_frees_input : assert property (@(posedge clock) disable iff (reset)
      (rsp_xfer && rsp_tlast) |=> req_tready)
      else $error("input not ready after final character");

endmodule

// ===== verif/integer_to_ascii_digits_test.sv =====
// ----------------------------------------------------------------------------
// integer_to_ascii_digits_test
// self-checking bench for the radix converter: a directed table (zero, the
// full-scale value, clamped radix codes, every radix 2..16) and then random
// values and radix codes, with random gaps on the request side and random
// back-pressure on the response side; every digit is checked against typed-in
// text or an in-bench conversion model
// ----------------------------------------------------------------------------
module integer_to_ascii_digits_test;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int RESET_CYCLES  = 11;
   localparam int RANDOM_ITEMS  = 256;
   localparam int DIRECTED_ROWS = 25;
   // longest correct quiet stretch is the serial division of one 64-digit
   // item, plus the longest gap on either side
   localparam int STALL_LIMIT   = 20000;
   localparam int SETTLE_CYCLES = 200;

   // one expected character on the response stream
   typedef struct packed {
      logic [itoa_pkg::CHAR_BITS-1:0] ch;
      logic                           last;
   } digit_out_type;

   // one row of the directed stimulus
   typedef struct packed {
      logic [itoa_pkg::VALUE_BITS-1:0] value;
      logic [itoa_pkg::RADIX_BITS-1:0] radix;
   } convert_req_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                             req_tvalid = 1'b0;
   logic                             req_tready;
   logic [itoa_pkg::REQ_TDATA_W-1:0] req_tdata  = '0;
   logic                             rsp_tvalid;
   logic                             rsp_tready = 1'b0;
   logic [itoa_pkg::RSP_TDATA_W-1:0] rsp_tdata;
   logic                             rsp_tlast;

   // random gaps on both sides only while this is high
   logic idle_enabled = 1'b1;

   digit_out_type pending_digits[$];
   int            mismatch_count = 0;
   int            sink_stall_left = 0;
   int            quiet_cycles = 0;

   // directed table; an empty text means the digits come from the model below
   convert_req_type directed_req [DIRECTED_ROWS] = '{
      '{64'd0,                      5'd10},
      '{64'd0,                      5'd2},
      '{64'd1,                      5'd2},
      '{64'hffff_ffff_ffff_ffff,    5'd16},
      '{64'hffff_ffff_ffff_ffff,    5'd10},
      '{64'hffff_ffff_ffff_ffff,    5'd2},
      '{64'd255,                    5'd0},
      '{64'd255,                    5'd1},
      '{64'd255,                    5'd17},
      '{64'd255,                    5'd31},
      '{64'd10,                     5'd16},
      '{64'h8000_0000_0000_0000,    5'd16},
      '{64'h0123_4567_89ab_cdef,    5'd16},
      '{64'hdead_beef_0bad_f00d,    5'd3},
      '{64'd1234567890123,          5'd4},
      '{64'hffff_ffff,              5'd5},
      '{64'd987654321,              5'd6},
      '{64'h8000_0000_0000_0000,    5'd7},
      '{64'd42,                     5'd8},
      '{64'hcafe_f00d_1234_5678,    5'd9},
      '{64'hffff_ffff_ffff_fffe,    5'd11},
      '{64'd1000,                   5'd12},
      '{64'h7fff_ffff_ffff_ffff,    5'd13},
      '{64'h0000_0100_0000_0000,    5'd14},
      '{64'd50625,                  5'd15}
   };

   string directed_text [DIRECTED_ROWS] = '{
      "0", "0", "1", "ffffffffffffffff", "18446744073709551615", "",
      "11111111", "11111111", "ff", "ff", "a", "8000000000000000",
      "123456789abcdef", "", "", "", "", "", "", "", "", "", "", "", ""
   };

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   integer_to_ascii_digits u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),   // value[63:0], radix[68:64], zero pad [71:69]
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),   // digit_char[6:0], zero pad [7]
      .rsp_tlast  (rsp_tlast)
   );

   // mostly short gaps, now and then a long one
   function automatic int pick_gap();
      if ($urandom_range(0, 9) == 0) begin
         return $urandom_range(8, 40);
      end
      return $urandom_range(1, 3);
   endfunction

   // repeated division by the clamped radix, digits queued most significant first
   function automatic void predict_digits(
         input logic [itoa_pkg::VALUE_BITS-1:0] value,
         input logic [itoa_pkg::RADIX_BITS-1:0] radix_code);
      logic [itoa_pkg::VALUE_BITS-1:0] rest;
      logic [itoa_pkg::VALUE_BITS-1:0] base;
      logic [itoa_pkg::DIGIT_BITS-1:0] digs [64];
      int                              n;
      digit_out_type                   d;
      if (radix_code < itoa_pkg::RADIX_MIN) begin
         base = itoa_pkg::VALUE_BITS'(itoa_pkg::RADIX_MIN);
      end else if (radix_code > itoa_pkg::RADIX_MAX) begin
         base = itoa_pkg::VALUE_BITS'(itoa_pkg::RADIX_MAX);
      end else begin
         base = itoa_pkg::VALUE_BITS'(radix_code);
      end
      rest = value;
      n = 0;
      // zero still yields one digit
      do begin
         digs[n] = itoa_pkg::DIGIT_BITS'(rest % base);
         rest    = rest / base;
         n++;
      end while (rest != 0 && n < 64);
      for (int k = n - 1; k >= 0; k--) begin
         if (digs[k] < itoa_pkg::DECIMAL_TEN) begin
            d.ch = itoa_pkg::CHAR_ZERO + itoa_pkg::CHAR_BITS'(digs[k]);
         end else begin
            d.ch = itoa_pkg::CHAR_LOWER_A + itoa_pkg::CHAR_BITS'(digs[k])
                   - itoa_pkg::CHAR_BITS'(itoa_pkg::DECIMAL_TEN);
         end
         d.last = (k == 0);
         pending_digits.push_back(d);
      end
   endfunction

   // expected digits typed in as text
   function automatic void queue_text(input string text);
      digit_out_type d;
      for (int i = 0; i < text.len(); i++) begin
         d.ch   = itoa_pkg::CHAR_BITS'(text[i]);
         d.last = (i == text.len() - 1);
         pending_digits.push_back(d);
      end
   endfunction

   task automatic report_mismatch(input string what);
      $display("MISMATCH @ %0t: %s", $realtime, what);
      mismatch_count++;
   endtask

   // one request transfer; the expectation is queued at the accepting edge
   task automatic send_request(input logic [itoa_pkg::VALUE_BITS-1:0] value,
                               input logic [itoa_pkg::RADIX_BITS-1:0] radix_code,
                               input string text);
      int gap;
      req_tdata  <= {3'b000, radix_code, value};
      req_tvalid <= 1'b1;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      if (text.len() != 0) begin
         queue_text(text);
      end else begin
         predict_digits(value, radix_code);
      end
      gap = (idle_enabled && $urandom_range(0, 1) == 0) ? pick_gap() : 0;
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // hold the request side until every queued digit has come out
   task automatic wait_digits_drained();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (pending_digits.size() != 0);
   endtask

   // response side: check each transfer and apply random back-pressure
   always @(posedge clock) begin : digit_sink
      digit_out_type want;
      if (reset) begin
         rsp_tready <= 1'b0;
         sink_stall_left = 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (pending_digits.size() == 0) begin
               report_mismatch($sformatf("digit 0x%02h with nothing expected", rsp_tdata));
            end else begin
               want = pending_digits.pop_front();
               if (rsp_tdata !== {1'b0, want.ch}) begin
                  report_mismatch($sformatf("char 0x%02h, expected 0x%02h", rsp_tdata, want.ch));
               end
               if (rsp_tlast !== want.last) begin
                  report_mismatch($sformatf("last %b, expected %b", rsp_tlast, want.last));
               end
            end
         end
         if (sink_stall_left == 0 && idle_enabled && $urandom_range(0, 4) == 0) begin
            sink_stall_left = pick_gap();
         end
         if (sink_stall_left > 0) begin
            rsp_tready <= 1'b0;
            sink_stall_left--;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // watchdog: too long without a transfer on either side
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
         $display("watchdog: no transfer for %0d cycles", STALL_LIMIT);
         $display("Test completed with failures");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin : stimulus
      logic [itoa_pkg::VALUE_BITS-1:0] value;
      logic [itoa_pkg::RADIX_BITS-1:0] radix_code;

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed table
      for (int r = 0; r < DIRECTED_ROWS; r++) begin
         send_request(directed_req[r].value, directed_req[r].radix, directed_text[r]);
      end
      wait_digits_drained();

      // random part; every third stretch of 40 items runs without gaps
      for (int i = 0; i < RANDOM_ITEMS; i++) begin
         idle_enabled <= ((i / 40) % 3) != 1;
         if (i == RANDOM_ITEMS / 2) begin
            wait_digits_drained();
         end
         value = {$urandom, $urandom};
         case ($urandom_range(0, 7))
            0:       value = itoa_pkg::VALUE_BITS'($urandom_range(0, 20));
            1:       value = '1;
            2, 3:    value = value >> $urandom_range(1, 63);
            default: ;
         endcase
         // mostly legal radix codes, some to be clamped
         if ($urandom_range(0, 9) == 0) begin
            radix_code = itoa_pkg::RADIX_BITS'($urandom_range(0, 31));
         end else begin
            radix_code = itoa_pkg::RADIX_BITS'($urandom_range(2, 16));
         end
         send_request(value, radix_code, "");
      end

      wait_digits_drained();
      // catch any stray digit after the last expected one
      repeat (SETTLE_CYCLES) @(posedge clock);

      if (mismatch_count == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
hw/rtl/itoa_pkg.sv
hw/rtl/itoa_div.sv
hw/rtl/integer_to_ascii_digits.sv
verif/integer_to_ascii_digits_test.sv
